[src/gds_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date subtract package
// Field widths, action codes and calendar helpers.
// ----------------------------------------------------------------------------
package gds_pkg;

    localparam int ACTION_W = 3;
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int COUNT_W  = 12;
    localparam int STEP_W   = 15;
    localparam int MULB_W   = 13;
    localparam int PROD_W   = YEAR_W + MULB_W;
    localparam int REM_W    = 7;
    localparam int QUO_W    = 8;
    localparam int DELTA_W  = 22;

    localparam logic [ACTION_W-1:0] ACT_DAYS       = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_WEEKS      = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_MONTHS     = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_YEARS      = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DECADES    = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_CENTURIES  = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_MILLENNIA  = 3'd6;

    localparam logic [MULB_W-1:0] MULT_YEAR       = 13'd1;
    localparam logic [MULB_W-1:0] MULT_DECADE     = 13'd10;
    localparam logic [MULB_W-1:0] MULT_CENTURY    = 13'd100;
    localparam logic [MULB_W-1:0] MULT_MILLENNIUM = 13'd1000;

    // Reciprocal of 100 scaled by 2**19; exact for every 14-bit year.
    localparam logic [MULB_W-1:0] RECIP_100   = 13'd5243;
    localparam int                RECIP_SHIFT = 19;
    localparam logic [REM_W-1:0]  REM_MAX     = 7'd99;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_MAX   = 5'd31;

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Length of month m (1..12) in a year with the given leap flag.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [MONTH_W-1:0] idx;
        idx = m - MONTH_JAN;
        if (m == MONTH_FEB) begin
            month_len = leap ? 5'd29 : 5'd28;
        end else begin
            month_len = MONTH_LEN[idx];
        end
    endfunction

endpackage

[src/gregorian_date_subtract.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date subtract
// Moves a date back by a count of days, weeks, months or year-type units.
// ----------------------------------------------------------------------------
// A request is taken when i_start is high and o_busy is low. The result is
// shown for exactly one cycle with o_done high, and the receiver cannot stall
// it. One multiplier first forms either the year delta or the year split by
// 100 for the leap rule; day and month steps are then walked one per cycle.
// Year-type actions and the unused code pass through ST_MUL and ST_PREP;
// month steps add ST_WALK, day and week steps add ST_CLAMP and ST_WALK, which
// walks n months, n days or 7n days (n = i_unit_count), ending on underflow.
// ----------------------------------------------------------------------------
module gregorian_date_subtract (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [gds_pkg::ACTION_W-1:0]  i_action,
    input  logic [gds_pkg::DAY_W-1:0]     i_in_day,
    input  logic [gds_pkg::MONTH_W-1:0]   i_in_month,
    input  logic [gds_pkg::YEAR_W-1:0]    i_in_year,
    input  logic [gds_pkg::COUNT_W-1:0]   i_unit_count,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [gds_pkg::DAY_W-1:0]     o_out_day,
    output logic [gds_pkg::MONTH_W-1:0]   o_out_month,
    output logic [gds_pkg::YEAR_W-1:0]    o_out_year,
    output logic                          o_year_underflow
);
    import gds_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MUL   = 5'b00010,
        ST_PREP  = 5'b00100,
        ST_CLAMP = 5'b01000,
        ST_WALK  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [ACTION_W-1:0] r_action, n_action;
    logic [DAY_W-1:0]    r_day, n_day;
    logic [MONTH_W-1:0]  r_month, n_month;
    logic [YEAR_W-1:0]   r_year, n_year;
    logic [STEP_W-1:0]   r_cnt, n_cnt;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [REM_W-1:0]    r_yr_rem, n_yr_rem;
    logic [1:0]          r_yr_qlo, n_yr_qlo;
    logic                r_uf, n_uf;
    logic                r_done, n_done;

    logic                is_year_act;
    logic                is_day_act;
    logic [YEAR_W-1:0]   mul_a;
    logic [MULB_W-1:0]   mul_b;
    logic [QUO_W-1:0]    quo;
    logic [YEAR_W-1:0]   quo100;
    logic [YEAR_W-1:0]   rem_full;
    logic [DELTA_W-1:0]  delta;
    logic                leap;
    logic [MONTH_W-1:0]  prev_month;
    logic [DAY_W-1:0]    cur_len;
    logic [DAY_W-1:0]    prev_len;

    assign is_year_act = (r_action >= ACT_YEARS) && (r_action <= ACT_MILLENNIA);
    assign is_day_act  = (r_action == ACT_DAYS) || (r_action == ACT_WEEKS);

    always_comb begin
        mul_a = r_year;
        mul_b = RECIP_100;
        if (is_year_act) begin
            mul_a = {{(YEAR_W-COUNT_W){1'b0}}, r_cnt[COUNT_W-1:0]};
            case (r_action)
                ACT_YEARS:     mul_b = MULT_YEAR;
                ACT_DECADES:   mul_b = MULT_DECADE;
                ACT_CENTURIES: mul_b = MULT_CENTURY;
                default:       mul_b = MULT_MILLENNIUM;
            endcase
        end
    end

    assign quo      = r_prod[RECIP_SHIFT +: QUO_W];
    assign quo100   = YEAR_W'({quo, 6'b0}) + YEAR_W'({quo, 5'b0}) + YEAR_W'({quo, 2'b0});
    assign rem_full = r_year - quo100;
    assign delta    = r_prod[DELTA_W-1:0];

    assign leap       = (r_yr_rem == '0) ? (r_yr_qlo == 2'd0) : (r_yr_rem[1:0] == 2'd0);
    assign prev_month = r_month - MONTH_JAN;
    assign cur_len    = month_len(r_month, leap);
    assign prev_len   = month_len(prev_month, leap);

    always_comb begin
        n_state  = r_state;
        n_action = r_action;
        n_day    = r_day;
        n_month  = r_month;
        n_year   = r_year;
        n_cnt    = r_cnt;
        n_prod   = r_prod;
        n_yr_rem = r_yr_rem;
        n_yr_qlo = r_yr_qlo;
        n_uf     = r_uf;
        n_done   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_action = i_action;
                    n_day    = (i_in_day == '0) ? DAY_FIRST : i_in_day;
                    if (i_in_month < MONTH_JAN) begin
                        n_month = MONTH_JAN;
                    end else if (i_in_month > MONTH_DEC) begin
                        n_month = MONTH_DEC;
                    end else begin
                        n_month = i_in_month;
                    end
                    n_year  = i_in_year;
                    n_cnt   = {{(STEP_W-COUNT_W){1'b0}}, i_unit_count};
                    n_uf    = 1'b0;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_prod  = {{(PROD_W-YEAR_W){1'b0}}, mul_a} *
                          {{(PROD_W-MULB_W){1'b0}}, mul_b};
                n_state = ST_PREP;
            end
            ST_PREP: begin
                n_yr_rem = rem_full[REM_W-1:0];
                n_yr_qlo = quo[1:0];
                if (r_action == ACT_WEEKS) begin
                    n_cnt = {r_cnt[STEP_W-4:0], 3'b0} - r_cnt;
                end
                if (is_year_act) begin
                    if (delta > {{(DELTA_W-YEAR_W){1'b0}}, r_year}) begin
                        n_year = '0;
                        n_uf   = 1'b1;
                    end else begin
                        n_year = r_year - delta[YEAR_W-1:0];
                    end
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else if (is_day_act) begin
                    n_state = ST_CLAMP;
                end else if (r_action == ACT_MONTHS) begin
                    n_state = ST_WALK;
                end else begin
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_CLAMP: begin
                if (r_day > cur_len) begin
                    n_day = cur_len;
                end
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (r_cnt == '0) begin
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                    if (is_day_act && (r_day > DAY_FIRST)) begin
                        n_day = r_day - 1'b1;
                    end else if (r_month > MONTH_JAN) begin
                        n_month = prev_month;
                        if (is_day_act || (r_day > prev_len)) begin
                            n_day = prev_len;
                        end
                    end else if (r_year != '0) begin
                        n_year  = r_year - 1'b1;
                        n_month = MONTH_DEC;
                        if (is_day_act) begin
                            n_day = DAY_MAX;
                        end
                        if (r_yr_rem == '0) begin
                            n_yr_rem = REM_MAX;
                            n_yr_qlo = r_yr_qlo - 1'b1;
                        end else begin
                            n_yr_rem = r_yr_rem - 1'b1;
                        end
                    end else begin
                        n_uf    = 1'b1;
                        n_done  = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_action <= n_action;
        r_day    <= n_day;
        r_month  <= n_month;
        r_year   <= n_year;
        r_cnt    <= n_cnt;
        r_prod   <= n_prod;
        r_yr_rem <= n_yr_rem;
        r_yr_qlo <= n_yr_qlo;
        r_uf     <= n_uf;
    end

    assign o_busy           = (r_state != ST_IDLE);
    assign o_done           = r_done;
    assign o_out_day        = r_day;
    assign o_out_month      = r_month;
    assign o_out_year       = r_year;
    assign o_year_underflow = r_uf;

endmodule
